// File: rtl/gdad_pkg.sv
`timescale 1ns / 1ps

package gdad_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int CountW = 12;

  // Running day sum: largest day plus largest count stays below 2**12
  localparam int SumW = 12;

  // year / 100 as (year * 5243) >> 19, exact for every 14-bit year
  localparam int Div100Mul   = 5243;
  localparam int Div100MulW  = 13;
  localparam int Div100Shift = 19;
  localparam int ProdW       = YearW + Div100MulW;
  localparam int CentW       = 8;   // century count, holds 16383/100 plus roll-over
  localparam int RemW        = 7;   // year mod 100

  localparam logic [MonthW-1:0] MonthsPerYear = MonthW'(12);

  // Month length; a month code outside 1..12 is screened out before use
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (month) inside
      4'd2:                      len = leap ? DayW'(29) : DayW'(28);
      4'd4, 4'd6, 4'd9, 4'd11:   len = DayW'(30);
      default:                   len = DayW'(31);
    endcase
    return len;
  endfunction

endpackage

// File: rtl/gregorian_date_add_days.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// -------  ---------  -------------------  --------------------------------------------
// in       input      in_valid / in_ready   start_day, start_month, start_year, days_to_add
// out      output     out_valid / out_ready result_day, result_month, result_year,
//                                           date_valid, year_changed
//
// An accepted item passes through S_DIV, S_REM and S_CHECK, then S_NORM, and waits in S_DONE
// until its result is loaded. The month-stepping loop in S_NORM does one compare and subtract
// of a month length per cycle until the day fits the month.
// Invalid dates and negative counts skip the loop and go from S_CHECK straight to S_DONE.
// rst is synchronous, active high, and clears the sequencer and the output valid flag.
// in_ready is high only while the sequencer is idle; the output register lets a new item in
// while the previous result still waits, and a finished item stalls in its last state until
// the output register is free.

module gregorian_date_add_days
  import gdad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DayW-1:0]   start_day,
  input  logic [MonthW-1:0] start_month,
  input  logic [YearW-1:0]  start_year,
  input  logic [CountW-1:0] days_to_add,

  output logic              out_valid,
  input  logic              out_ready,
  output logic [DayW-1:0]   result_day,
  output logic [MonthW-1:0] result_month,
  output logic [YearW-1:0]  result_year,
  output logic              date_valid,
  output logic              year_changed
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,  // waiting for an item
    S_DIV   = 6'b000010,  // century count by reciprocal multiply
    S_REM   = 6'b000100,  // year mod 100
    S_CHECK = 6'b001000,  // date check, add the count
    S_NORM  = 6'b010000,  // one month per cycle
    S_DONE  = 6'b100000   // wait for the output register
  } state_t;

  state_t state, state_next;

  // Working registers (payload, no reset)
  logic [SumW-1:0]   day;
  logic [MonthW-1:0] month;
  logic [YearW-1:0]  year;
  logic [YearW-1:0]  year0;
  logic [CountW-1:0] count;
  logic [CentW-1:0]  cent;   // year / 100, tracks the unwrapped year
  logic [RemW-1:0]   rem;    // year mod 100
  logic              valid;

  logic              leap;
  logic [DayW-1:0]   len;
  logic              month_ok;
  logic              load_out;
  logic [ProdW-1:0]  prod;

  // Leap year: divisible by 4, and either not by 100 or by 400
  assign leap     = (year[1:0] == 2'b00) && ((rem != '0) || (cent[1:0] == 2'b00));
  assign len      = month_len(month, leap);
  assign month_ok = (month != '0) && (month <= MonthsPerYear);
  assign prod     = ProdW'(year) * ProdW'(Div100Mul);

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_DIV;
      S_DIV:   state_next = S_REM;
      S_REM:   state_next = S_CHECK;
      S_CHECK: begin
        if ((year != '0) && month_ok && (day != '0) && (day <= SumW'(len))
            && !count[CountW-1]) begin
          state_next = S_NORM;
        end else begin
          state_next = S_DONE;
        end
      end
      S_NORM:  if (day <= SumW'(len)) state_next = S_DONE;
      S_DONE:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          day   <= SumW'(start_day);
          month <= start_month;
          year  <= start_year;
          year0 <= start_year;
          count <= days_to_add;
        end
      end
      S_DIV: begin
        cent <= prod[Div100Shift +: CentW];
      end
      S_REM: begin
        rem <= RemW'(year - YearW'(cent) * YearW'(100));
      end
      S_CHECK: begin
        valid <= (year != '0) && month_ok && (day != '0) && (day <= SumW'(len));
        if ((year != '0) && month_ok && (day != '0) && (day <= SumW'(len))
            && !count[CountW-1]) begin
          day <= day + count;
        end
      end
      S_NORM: begin
        if (day > SumW'(len)) begin
          day <= day - SumW'(len);
          if (month == MonthsPerYear) begin
            month <= MonthW'(1);
            year  <= year + YearW'(1);
            if (rem == RemW'(99)) begin
              rem  <= '0;
              cent <= cent + CentW'(1);
            end else begin
              rem  <= rem + RemW'(1);
            end
          end else begin
            month <= month + MonthW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result_day   <= day[DayW-1:0];
      result_month <= month;
      result_year  <= year;
      date_valid   <= valid;
      year_changed <= valid && (year != year0);
    end
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_DIV)
    else $error("accepted item did not start the sequence");

  a_norm_month: assert property (@(posedge clk) disable iff (rst)
    state == S_NORM |-> month_ok)
    else $error("month out of range while stepping");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == S_NORM |-> rem < RemW'(100))
    else $error("year remainder out of range");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside the final state");

endmodule
